@@ hdl/sprt_pkg.sv @@
package sprt_pkg;

   typedef enum logic [2:0] {
      EV_REJECT   = 3'd0,
      EV_ACCEPT   = 3'd1,
      EV_COMPLETE = 3'd2,
      EV_EVICT    = 3'd3,
      EV_STALE    = 3'd4
   } event_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PACKET,
      ST_EVICT_OUT,
      ST_RESULT_OUT,
      ST_FLUSH_SCAN,
      ST_FLUSH_OUT
   } state_type;

   localparam int SLOT_W = 32;
   localparam int PRB_W  = 9;
   localparam int SYM_W  = 4;
   localparam int CNT_W  = 5;

   typedef struct packed {
      logic load;        // capture input item
      logic lookup;      // run packet lookup and update, latch result
      logic flush_step;  // examine current flush bucket
      logic flush_next;  // advance flush index
      logic rsp_fire;    // result transfer completed
   } cmd_type;

   typedef struct packed {
      logic is_flush;
      logic evicting;    // eviction result precedes packet result
      logic stale_hit;   // current flush bucket is stale
      logic flush_done;  // current flush bucket is the last one, or no later bucket is stale
   } status_type;

endpackage

@@ hdl/sprt_controller.sv @@
module sprt_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  sprt_pkg::status_type  status,
   output sprt_pkg::cmd_type     cmd,
   output logic                  rsp_last
);

   sprt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sprt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sprt_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = sprt_pkg::ST_PACKET;
         end
         sprt_pkg::ST_PACKET: begin
            if (status.is_flush) state_in = sprt_pkg::ST_FLUSH_SCAN;
            else if (status.evicting) state_in = sprt_pkg::ST_EVICT_OUT;
            else state_in = sprt_pkg::ST_RESULT_OUT;
         end
         sprt_pkg::ST_EVICT_OUT: begin
            if (rsp_tready) state_in = sprt_pkg::ST_RESULT_OUT;
         end
         sprt_pkg::ST_RESULT_OUT: begin
            if (rsp_tready) state_in = sprt_pkg::ST_IDLE;
         end
         sprt_pkg::ST_FLUSH_SCAN: begin
            if (status.stale_hit) state_in = sprt_pkg::ST_FLUSH_OUT;
            else if (status.flush_done) state_in = sprt_pkg::ST_IDLE;
         end
         sprt_pkg::ST_FLUSH_OUT: begin
            if (rsp_tready) begin
               state_in = status.flush_done ? sprt_pkg::ST_IDLE : sprt_pkg::ST_FLUSH_SCAN;
            end
         end
         default: state_in = sprt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      rsp_last   = 1'b0;
      unique case (state_ff)
         sprt_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         sprt_pkg::ST_PACKET: begin
            cmd.lookup = !status.is_flush;
         end
         sprt_pkg::ST_EVICT_OUT: begin
            rsp_tvalid   = 1'b1;
            cmd.rsp_fire = rsp_tready;
         end
         sprt_pkg::ST_RESULT_OUT: begin
            rsp_tvalid   = 1'b1;
            rsp_last     = 1'b1;
            cmd.rsp_fire = rsp_tready;
         end
         sprt_pkg::ST_FLUSH_SCAN: begin
            cmd.flush_step = 1'b1;
            cmd.flush_next = !status.stale_hit;
         end
         sprt_pkg::ST_FLUSH_OUT: begin
            rsp_tvalid     = 1'b1;
            rsp_last       = status.flush_done;
            cmd.rsp_fire   = rsp_tready;
            cmd.flush_next = rsp_tready;
         end
         default: begin
         end
      endcase
   end

endmodule

@@ hdl/sprt_datapath.sv @@
module sprt_datapath #(
   parameter int BUCKETS     = 4,
   parameter int MAX_PORTS   = 4,
   parameter int MAX_SYMBOLS = 4,
   parameter int TAG_BITS    = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [8:0]            csr_wdata,
   input  logic                  csr_we,
   input  logic [103:0]          req_tdata,
   input  logic                  req_tuser,
   input  sprt_pkg::cmd_type     cmd,
   output sprt_pkg::status_type  status,
   output logic [95:0]           rsp_tdata
);

   localparam int CELLS = MAX_PORTS * MAX_SYMBOLS;
   localparam int BI_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int CI_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int TS_W  = (BUCKETS * CELLS > 1) ? $clog2(BUCKETS * CELLS) : 1;

   logic [8:0] cell_prbs_ff;
   always_ff @(posedge clock) begin
      if (reset) cell_prbs_ff <= 9'd273;
      else if (csr_we) cell_prbs_ff <= csr_wdata;
   end

   logic        mode_ff;
   logic [31:0] slot_ff;
   logic [3:0]  sym_ff, port_ff, fsym_ff, nsym_ff;
   logic [8:0]  prbs_ff, fprb_ff;
   logic [4:0]  nport_ff;
   logic [15:0] keep_ff, tag_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= req_tuser;
         slot_ff  <= req_tdata[31:0];
         sym_ff   <= req_tdata[35:32];
         port_ff  <= req_tdata[39:36];
         prbs_ff  <= req_tdata[48:40];
         fprb_ff  <= req_tdata[57:49];
         fsym_ff  <= req_tdata[61:58];
         nsym_ff  <= req_tdata[65:62];
         nport_ff <= req_tdata[70:66];
         keep_ff  <= req_tdata[86:71];
         tag_ff   <= req_tdata[102:87];
      end
   end

   logic              used_ff  [BUCKETS];
   logic [31:0]       bslot_ff [BUCKETS];
   logic [4:0]        arr_ff   [BUCKETS];
   logic [4:0]        exp_ff   [BUCKETS];
   logic [3:0]        bsym_ff  [BUCKETS];
   logic [3:0]        bfsym_ff [BUCKETS];
   logic [8:0]        bprbs_ff [BUCKETS];
   logic [8:0]        bfprb_ff [BUCKETS];
   logic [CELLS-1:0]  map_ff   [BUCKETS];

   logic [TAG_BITS-1:0] tag_mem [BUCKETS*CELLS];

   // Range check on the captured packet.
   logic [3:0] off;
   logic       range_bad;
   assign off = sym_ff - fsym_ff;
   assign range_bad = (sym_ff < fsym_ff) || ({1'b0, port_ff} >= nport_ff) ||
                      (nport_ff > 5'(MAX_PORTS)) || (nsym_ff == 4'd0) ||
                      (nsym_ff > 4'(MAX_SYMBOLS)) || (off >= nsym_ff);

   // Bucket lookup: matching bucket, else first free, else bucket 0.
   logic [BI_W-1:0] hit_idx, free_idx, sel;
   logic            hit, free_any;
   always_comb begin
      hit = 1'b0; free_any = 1'b0; hit_idx = '0; free_idx = '0;
      for (int b = BUCKETS - 1; b >= 0; b--) begin
         if (used_ff[b] && bslot_ff[b] == slot_ff) begin
            hit = 1'b1; hit_idx = BI_W'(b);
         end
         if (!used_ff[b]) begin
            free_any = 1'b1; free_idx = BI_W'(b);
         end
      end
      sel = hit ? hit_idx : (free_any ? free_idx : '0);
   end
   logic fresh, evict;
   assign evict = !hit && !free_any;
   assign fresh = !hit;

   logic [8:0] cell_full;
   logic [CI_W-1:0] cell_idx;
   logic [4:0] arr_base, exp_new, arr_next;
   logic [3:0] nsym_eff;
   logic       first_pkt, dup;
   assign cell_full = 9'(port_ff) * 9'(nsym_ff) + 9'(off);
   assign cell_idx = cell_full[CI_W-1:0];
   assign arr_base = fresh ? 5'd0 : arr_ff[sel];
   assign first_pkt = (arr_base == 5'd0);
   assign nsym_eff = first_pkt ? nsym_ff : bsym_ff[sel];
   assign exp_new = first_pkt ? 5'(nport_ff * nsym_ff) : exp_ff[sel];
   assign dup = (cell_full >= 9'(CELLS)) || (!fresh && map_ff[sel][cell_idx]);
   assign arr_next = arr_base + 5'd1;

   // Latched result and flush scan index.
   logic [BI_W:0]  fidx_ff;
   logic [BI_W-1:0] fb;
   logic           evict_ff;
   logic [95:0]    res_ff, evres_ff;
   assign fb = fidx_ff[BI_W-1:0];

   function automatic logic [95:0] pack(input logic [2:0] ev, input logic [BI_W-1:0] b,
      input logic [31:0] s, input logic [4:0] a, input logic [4:0] e, input logic [8:0] p,
      input logic [8:0] fp, input logic [3:0] fs, input logic [3:0] ns,
      input logic [15:0] rel);
      pack = {7'd0, rel, ns, fs, fp, p, e, a, s, 2'(b), ev};
   endfunction

   logic stale;
   assign stale = used_ff[fb] && ((slot_ff - bslot_ff[fb]) > {16'd0, keep_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < BUCKETS; b++) begin
            used_ff[b] <= 1'b0; bslot_ff[b] <= '0; arr_ff[b] <= '0; exp_ff[b] <= '0;
            bsym_ff[b] <= '0; bfsym_ff[b] <= '0; bprbs_ff[b] <= '0; bfprb_ff[b] <= '0;
            map_ff[b] <= '0;
         end
         fidx_ff <= '0;
         evict_ff <= 1'b0;
      end else begin
         if (cmd.load) fidx_ff <= '0;
         if (cmd.lookup) begin
            evict_ff  <= !range_bad && evict;
            evres_ff  <= pack(sprt_pkg::EV_EVICT, '0, bslot_ff[0], arr_ff[0], exp_ff[0],
                              bprbs_ff[0], bfprb_ff[0], bfsym_ff[0], bsym_ff[0], 16'd0);
            if (range_bad) begin
               res_ff <= pack(sprt_pkg::EV_REJECT, '0, '0, '0, '0, '0, '0, '0, '0, tag_ff);
            end else begin
               logic [8:0] p_v, fp_v;
               logic [3:0] fs_v;
               p_v  = first_pkt ? ((prbs_ff == 9'd0) ? cell_prbs_ff : prbs_ff) : bprbs_ff[sel];
               fp_v = first_pkt ? fprb_ff : bfprb_ff[sel];
               fs_v = first_pkt ? fsym_ff : bfsym_ff[sel];
               bsym_ff[sel] <= nsym_eff; bfsym_ff[sel] <= fs_v;
               bprbs_ff[sel] <= p_v; bfprb_ff[sel] <= fp_v;
               if (dup) begin
                  res_ff <= pack(sprt_pkg::EV_REJECT, sel, slot_ff, arr_base, exp_new, p_v,
                                 fp_v, fs_v, nsym_eff, tag_ff);
                  used_ff[sel] <= 1'b1; bslot_ff[sel] <= slot_ff;
                  arr_ff[sel] <= arr_base; exp_ff[sel] <= exp_new;
                  if (fresh) map_ff[sel] <= '0;
               end else if (arr_next == exp_new) begin
                  res_ff <= pack(sprt_pkg::EV_COMPLETE, sel, slot_ff, arr_next, exp_new, p_v,
                                 fp_v, fs_v, nsym_eff, 16'd0);
                  used_ff[sel] <= 1'b0; bslot_ff[sel] <= '0;
                  arr_ff[sel] <= '0; exp_ff[sel] <= '0; map_ff[sel] <= '0;
               end else begin
                  res_ff <= pack(sprt_pkg::EV_ACCEPT, sel, slot_ff, arr_next, exp_new, p_v,
                                 fp_v, fs_v, nsym_eff, 16'd0);
                  used_ff[sel] <= 1'b1; bslot_ff[sel] <= slot_ff;
                  arr_ff[sel] <= arr_next; exp_ff[sel] <= exp_new;
                  map_ff[sel] <= (fresh ? '0 : map_ff[sel]) | (CELLS'(1) << cell_idx);
               end
            end
         end
         if (cmd.flush_step && stale) begin
            res_ff <= pack(sprt_pkg::EV_STALE, fb, bslot_ff[fb], arr_ff[fb], exp_ff[fb],
                           bprbs_ff[fb], bfprb_ff[fb], bfsym_ff[fb], bsym_ff[fb], 16'd0);
            used_ff[fb] <= 1'b0; bslot_ff[fb] <= '0; arr_ff[fb] <= '0;
            exp_ff[fb] <= '0; map_ff[fb] <= '0;
         end
         if (cmd.flush_next) fidx_ff <= fidx_ff + 1'b1;
         if (cmd.rsp_fire) evict_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup && !range_bad && !dup) begin
         tag_mem[TS_W'(sel) * TS_W'(CELLS) + TS_W'(cell_idx)] <= TAG_BITS'(tag_ff);
      end
   end

   // Pending stale bucket: look ahead so the last flush result carries tlast.
   logic more_stale;
   always_comb begin
      more_stale = 1'b0;
      for (int b = 0; b < BUCKETS; b++) begin
         if (BI_W'(b) > fb && used_ff[b] &&
             ((slot_ff - bslot_ff[b]) > {16'd0, keep_ff})) more_stale = 1'b1;
      end
   end

   assign rsp_tdata = evict_ff ? evres_ff : res_ff;

   assign status.is_flush   = mode_ff;
   assign status.evicting   = evict && !range_bad;
   assign status.stale_hit  = stale;
   assign status.flush_done = (32'(fidx_ff) >= 32'(BUCKETS - 1)) || !more_stale;

endmodule

@@ hdl/slot_packet_reassembly_tracker_unit.sv @@
// Slot packet reassembly tracker. A packet's first result follows its transfer
// through the capture register and the bucket lookup and update; each result
// then waits for rsp_tready, and an eviction for space adds one result before
// the packet's own. A flush tick scans one bucket per cycle, stops for each
// stale bucket while its result is transferred, and ends once no later bucket
// is stale. The next request is taken when the last result of the previous
// one has been transferred.
module slot_packet_reassembly_tracker_unit #(
   parameter int BUCKETS     = 4,
   parameter int MAX_PORTS   = 4,
   parameter int MAX_SYMBOLS = 4,
   parameter int TAG_BITS    = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic [8:0]    csr_wdata,
   input  logic          req_tvalid,
   output logic          req_tready,
   // slot_tag, symbol_index, port_index, prb_count, first_prb, first_symbol,
   // symbol_count, port_count, keepalive, buffer_tag
   input  logic [103:0]  req_tdata,
   input  logic          req_tuser,  // mode
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // event_res, bucket, slot_out, arrived_count, expected_count, prbs_out,
   // first_prb_out, first_symbol_out, symbols_out, release_tag
   output logic [95:0]   rsp_tdata,
   output logic          rsp_tlast
);

   sprt_pkg::cmd_type    cmd;
   sprt_pkg::status_type status;

   sprt_controller u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .status, .cmd, .rsp_last(rsp_tlast)
   );

   sprt_datapath #(
      .BUCKETS(BUCKETS), .MAX_PORTS(MAX_PORTS),
      .MAX_SYMBOLS(MAX_SYMBOLS), .TAG_BITS(TAG_BITS)
   ) u_dp (
      .clock, .reset, .csr_wdata, .csr_we, .req_tdata, .req_tuser,
      .cmd, .status, .rsp_tdata
   );

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("request taken while result pending");

   a_evict_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[2:0] == sprt_pkg::EV_EVICT) |-> !rsp_tlast)
      else $error("eviction result marked last");

   a_pack_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[95:89] == '0) else $error("padding bits set");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

   localparam int NBKT = 4;
   localparam int NPORT = 4;
   localparam int NSYM = 4;
   localparam int NCELL = NPORT * NSYM;

   typedef struct packed {
      logic [15:0] buffer_tag;
      logic [15:0] keepalive;
      logic [4:0]  port_count;
      logic [3:0]  symbol_count;
      logic [3:0]  first_symbol;
      logic [8:0]  first_prb;
      logic [8:0]  prb_count;
      logic [3:0]  port_index;
      logic [3:0]  symbol_index;
      logic [31:0] slot_tag;
   } packet_fields;

   typedef struct packed {
      logic [15:0] release_tag;
      logic [3:0]  symbols;
      logic [3:0]  first_symbol;
      logic [8:0]  first_prb;
      logic [8:0]  prbs;
      logic [4:0]  expected;
      logic [4:0]  arrived;
      logic [31:0] slot;
      logic [1:0]  bucket;
      sprt_pkg::event_type ev;
   } tracker_event;

   typedef struct {
      tracker_event ev;
      logic last;
   } event_entry;

   typedef struct {
      logic mode;
      packet_fields f;
      logic check_ev;
      sprt_pkg::event_type ev;
   } stim_row;

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [8:0] csr_wdata = '0;
   logic req_tvalid = 0;
   logic req_tready;
   logic [103:0] req_tdata = '0;
   logic req_tuser = 0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [95:0] rsp_tdata;
   logic rsp_tlast;

   slot_packet_reassembly_tracker_unit dut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   always #5 clock = ~clock;

   initial begin
      #5ms;
      $display("** slot_packet_reassembly_tracker_unit: FAILED **");
      $finish;
   end

   logic [8:0]  cell_prbs;
   logic        b_used [NBKT];
   logic [31:0] b_slot [NBKT];
   logic [4:0]  b_arrived [NBKT];
   logic [4:0]  b_expected [NBKT];
   logic [3:0]  b_symbols [NBKT];
   logic [3:0]  b_fsym [NBKT];
   logic [8:0]  b_prbs [NBKT];
   logic [8:0]  b_fprb [NBKT];
   logic [NCELL-1:0] b_filled [NBKT];

   event_entry pending_events[$];
   int errors = 0;
   bit hold_off = 0;

   function automatic tracker_event bucket_view(sprt_pkg::event_type e, int b,
                                                logic [15:0] rel);
      tracker_event t;
      t = '0;
      t.ev = e;
      t.release_tag = rel;
      if (b >= 0) begin
         t.bucket = b[1:0];
         t.slot = b_slot[b];
         t.arrived = b_arrived[b];
         t.expected = b_expected[b];
         t.prbs = b_prbs[b];
         t.first_prb = b_fprb[b];
         t.first_symbol = b_fsym[b];
         t.symbols = b_symbols[b];
      end
      return t;
   endfunction

   function automatic void free_bucket(int b);
      b_used[b] = 0;
      b_slot[b] = '0;
      b_arrived[b] = '0;
      b_expected[b] = '0;
      b_filled[b] = '0;
   endfunction

   function automatic void reset_tracker();
      cell_prbs = 9'd273;
      for (int b = 0; b < NBKT; b++) begin
         free_bucket(b);
         b_symbols[b] = '0;
         b_fsym[b] = '0;
         b_prbs[b] = '0;
         b_fprb[b] = '0;
      end
   endfunction

   function automatic void push_event(tracker_event t);
      event_entry e;
      e.ev = t;
      e.last = 0;
      pending_events.push_back(e);
   endfunction

   function automatic void track_transfer(logic mode, packet_fields f);
      int found;
      int n0;
      logic [3:0] off;
      int cell_idx;
      n0 = pending_events.size();
      found = -1;
      if (mode) begin
         for (int b = 0; b < NBKT; b++)
            if (b_used[b] && (f.slot_tag - b_slot[b]) > {16'd0, f.keepalive}) begin
               push_event(bucket_view(sprt_pkg::EV_STALE, b, '0));
               free_bucket(b);
            end
      end else if (f.symbol_index < f.first_symbol || f.port_index >= f.port_count ||
                   f.port_count > NPORT || f.symbol_count == 0 ||
                   f.symbol_count > NSYM ||
                   f.symbol_index - f.first_symbol >= f.symbol_count) begin
         push_event(bucket_view(sprt_pkg::EV_REJECT, -1, f.buffer_tag));
      end else begin
         off = f.symbol_index - f.first_symbol;
         for (int b = 0; b < NBKT && found < 0; b++)
            if (b_used[b] && b_slot[b] == f.slot_tag) found = b;
         for (int b = 0; b < NBKT && found < 0; b++)
            if (!b_used[b]) begin
               found = b;
               b_used[b] = 1;
               b_slot[b] = f.slot_tag;
               b_arrived[b] = '0;
               b_filled[b] = '0;
            end
         if (found < 0) begin
            found = 0;
            push_event(bucket_view(sprt_pkg::EV_EVICT, 0, '0));
            free_bucket(0);
            b_used[0] = 1;
            b_slot[0] = f.slot_tag;
         end
         if (b_arrived[found] == 0) begin
            b_symbols[found] = f.symbol_count;
            b_fsym[found] = f.first_symbol;
            b_prbs[found] = (f.prb_count == 0) ? cell_prbs : f.prb_count;
            b_fprb[found] = f.first_prb;
            b_expected[found] = f.port_count * f.symbol_count;
         end
         cell_idx = f.port_index * f.symbol_count + off;
         if (cell_idx >= NCELL || b_filled[found][cell_idx]) begin
            push_event(bucket_view(sprt_pkg::EV_REJECT, found, f.buffer_tag));
         end else begin
            b_filled[found][cell_idx] = 1;
            b_arrived[found]++;
            if (b_arrived[found] == b_expected[found]) begin
               push_event(bucket_view(sprt_pkg::EV_COMPLETE, found, '0));
               free_bucket(found);
            end else begin
               push_event(bucket_view(sprt_pkg::EV_ACCEPT, found, '0));
            end
         end
      end
      if (pending_events.size() > n0)
         pending_events[pending_events.size()-1].last = 1;
   endfunction

   // Result side: random stalls, plus a long hold-off when requested.
   initial begin
      int waitn;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_tready <= 0;
            repeat (60) @(negedge clock);
            hold_off = 0;
         end
         waitn = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
         if (waitn > 0) begin
            rsp_tready <= 0;
            repeat (waitn) @(negedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      tracker_event got;
      event_entry want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = tracker_event'(rsp_tdata[88:0]);
         if (pending_events.size() == 0) begin
            $display("%0t: unexpected result %h last %b", $time, rsp_tdata, rsp_tlast);
            errors++;
         end else begin
            want = pending_events.pop_front();
            if (got !== want.ev || rsp_tlast !== want.last) begin
               $display("%0t: expected ev %0d bkt %0d slot %h arr %0d exp %0d prbs %0d",
                  $time, want.ev.ev, want.ev.bucket, want.ev.slot, want.ev.arrived,
                  want.ev.expected, want.ev.prbs);
               $display("   fprb %0d fsym %0d nsym %0d rel %h last %b",
                  want.ev.first_prb, want.ev.first_symbol, want.ev.symbols,
                  want.ev.release_tag, want.last);
               $display("   actual ev %0d bkt %0d slot %h arr %0d exp %0d prbs %0d",
                  got.ev, got.bucket, got.slot, got.arrived, got.expected, got.prbs);
               $display("   fprb %0d fsym %0d nsym %0d rel %h last %b",
                  got.first_prb, got.first_symbol, got.symbols, got.release_tag, rsp_tlast);
               errors++;
            end
         end
      end
   end

   task automatic send_item(logic mode, packet_fields f, bit gaps);
      int waitn;
      waitn = gaps ? $urandom_range(0, 7) : 0;
      if (waitn > 0) begin
         req_tvalid <= 0;
         repeat (waitn) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= mode;
      req_tdata <= {1'b0, f};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      track_transfer(mode, f);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (pending_events.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_cell_prbs(logic [8:0] v);
      csr_we <= 1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 0;
      cell_prbs = v;
   endtask

   function automatic packet_fields make_packet(logic [31:0] slot, int sym, int port,
                                                int nsym, int nport, int fsym);
      packet_fields f;
      f = '0;
      f.slot_tag = slot;
      f.symbol_index = 4'(sym);
      f.port_index = 4'(port);
      f.symbol_count = 4'(nsym);
      f.port_count = 5'(nport);
      f.first_symbol = 4'(fsym);
      f.prb_count = ($urandom_range(0, 3) == 0) ? 9'd0 : 9'($urandom_range(1, 275));
      f.first_prb = 9'($urandom_range(0, 274));
      f.keepalive = 16'($urandom);
      f.buffer_tag = 16'($urandom);
      return f;
   endfunction

   function automatic stim_row row(logic mode, packet_fields f, logic chk,
                                   sprt_pkg::event_type e);
      stim_row r;
      r.mode = mode;
      r.f = f;
      r.check_ev = chk;
      r.ev = e;
      return r;
   endfunction

   initial begin
      stim_row rows[$];
      packet_fields f;
      logic [31:0] slots[4];
      int nsym, nport, fsym;

      reset_tracker();
      repeat (11) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed part: range rejects, extremes, duplicate, eviction, completion, flush.
      f = make_packet(32'hFFFF_FFFF, 0, 0, 1, 1, 0); f.prb_count = 0;
      rows.push_back(row(1'b0, f, 1'b1, sprt_pkg::EV_COMPLETE));
      f = make_packet(32'd5, 2, 0, 4, 4, 3);
      rows.push_back(row(1'b0, f, 1'b1, sprt_pkg::EV_REJECT));
      f = make_packet(32'd5, 0, 4, 4, 4, 0);
      rows.push_back(row(1'b0, f, 1'b1, sprt_pkg::EV_REJECT));
      f = make_packet(32'd5, 0, 0, 4, 16, 0);
      rows.push_back(row(1'b0, f, 1'b1, sprt_pkg::EV_REJECT));
      f = make_packet(32'd5, 0, 0, 0, 4, 0);
      rows.push_back(row(1'b0, f, 1'b1, sprt_pkg::EV_REJECT));
      f = make_packet(32'd5, 13, 15, 15, 16, 13);
      rows.push_back(row(1'b0, f, 1'b1, sprt_pkg::EV_REJECT));
      f = make_packet(32'd5, 13, 0, 4, 4, 9);
      rows.push_back(row(1'b0, f, 1'b1, sprt_pkg::EV_REJECT));
      f = make_packet(32'd10, 13, 3, 4, 4, 10); f.prb_count = 275; f.first_prb = 274;
      f.buffer_tag = 16'hFFFF; f.keepalive = 16'hFFFF;
      rows.push_back(row(1'b0, f, 1'b1, sprt_pkg::EV_ACCEPT));
      f = make_packet(32'd10, 13, 3, 4, 4, 10);
      rows.push_back(row(1'b0, f, 1'b1, sprt_pkg::EV_REJECT));
      f = make_packet(32'd11, 0, 0, 2, 2, 0);
      rows.push_back(row(1'b0, f, 1'b1, sprt_pkg::EV_ACCEPT));
      f = make_packet(32'd12, 0, 0, 2, 2, 0);
      rows.push_back(row(1'b0, f, 1'b1, sprt_pkg::EV_ACCEPT));
      f = make_packet(32'd13, 0, 0, 2, 2, 0);
      rows.push_back(row(1'b0, f, 1'b1, sprt_pkg::EV_ACCEPT));
      f = make_packet(32'd14, 1, 1, 2, 2, 0);
      rows.push_back(row(1'b0, f, 1'b0, sprt_pkg::EV_ACCEPT));
      f = make_packet(32'd14, 0, 0, 2, 1, 0);
      rows.push_back(row(1'b0, f, 1'b0, sprt_pkg::EV_ACCEPT));
      f = make_packet(32'd14, 1, 0, 2, 1, 0);
      rows.push_back(row(1'b0, f, 1'b0, sprt_pkg::EV_ACCEPT));
      f = '0; f.slot_tag = 32'd13; f.keepalive = 16'd0;
      rows.push_back(row(1'b1, f, 1'b0, sprt_pkg::EV_STALE));
      f = '0; f.slot_tag = 32'd1; f.keepalive = 16'hFFFF;
      rows.push_back(row(1'b1, f, 1'b0, sprt_pkg::EV_STALE));
      f = '0; f.slot_tag = 32'hFFFF_FFFF; f.keepalive = 16'd0;
      rows.push_back(row(1'b1, f, 1'b0, sprt_pkg::EV_STALE));
      f = '0; f.slot_tag = 32'd0;
      rows.push_back(row(1'b1, f, 1'b0, sprt_pkg::EV_STALE));

      foreach (rows[i]) begin
         if (rows[i].check_ev && !rows[i].mode) begin
            send_item(1'b0, rows[i].f, 1'b1);
            if (pending_events[pending_events.size()-1].ev.ev != rows[i].ev) begin
               $display("%0t: directed row %0d expected event %0d, model gives %0d",
                  $time, i, rows[i].ev, pending_events[pending_events.size()-1].ev.ev);
               errors++;
            end
         end else begin
            send_item(rows[i].mode, rows[i].f, 1'b1);
         end
      end
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: write_cell_prbs(9'd1);
            1: write_cell_prbs(9'd275);
            2: write_cell_prbs(9'($urandom_range(1, 511)));
            default: write_cell_prbs(9'd273);
         endcase
         if (phase == 1) hold_off = 1;
         for (int k = 0; k < 23; k++) begin
            if (k % 7 == 0)
               for (int s = 0; s < 4; s++) slots[s] = $urandom_range(0, 3) == 0 ?
                  $urandom : $urandom_range(0, 40);
            case ($urandom_range(0, 9))
               0: begin
                  f = '0;
                  f.slot_tag = $urandom_range(0, 60);
                  f.keepalive = $urandom_range(0, 3) == 0 ? 16'($urandom) :
                     16'($urandom_range(0, 30));
                  send_item(1'b1, f, 1'b1);
               end
               1: begin
                  f = make_packet($urandom, $urandom_range(0, 15), $urandom_range(0, 15),
                     $urandom_range(0, 15), $urandom_range(0, 31), $urandom_range(0, 15));
                  send_item(1'b0, f, 1'b1);
               end
               default: begin
                  nsym = $urandom_range(1, 4);
                  nport = $urandom_range(1, 4);
                  fsym = $urandom_range(0, 13 - nsym + 1);
                  f = make_packet(slots[$urandom_range(0, 3)],
                     fsym + $urandom_range(0, nsym - 1), $urandom_range(0, nport - 1),
                     nsym, nport, fsym);
                  send_item(1'b0, f, phase != 2);
               end
            endcase
         end
         drain();
      end

      if (errors == 0) begin
         $display("** slot_packet_reassembly_tracker_unit: PASSED **");
      end else begin
         $display("** slot_packet_reassembly_tracker_unit: FAILED **");
      end
      $finish;
   end

endmodule
